/* rtl/hscp_pkg.sv */
// Shared types, constants and helper functions for the half-shell cell pair generator.
`timescale 1ns / 1ps
`default_nettype none

package hscp_pkg;

    // Grid size limit and the widths that follow from it
    localparam int MAX_CELLS_PER_AXIS = 64;
    localparam int COORD_W            = $clog2(MAX_CELLS_PER_AXIS);
    localparam int DIM_W              = COORD_W + 1;
    localparam int PLANE_W            = 2 * COORD_W + 1;
    localparam int PROD_X_W           = COORD_W + PLANE_W;
    localparam int PROD_Y_W           = COORD_W + DIM_W;

    // Fixed field widths of the stream and configuration ports
    localparam int IN_COORD_W  = 6;
    localparam int IDX_W       = 18;
    localparam int IMG_W       = 2;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 48;
    localparam int M_PAD_W     = M_TDATA_W - 2 * IDX_W - 3 * IMG_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 7;

    // Half-shell offset walk
    localparam int NUM_OFFSETS = 14;
    localparam int OFF_IDX_W   = $clog2(NUM_OFFSETS);
    localparam logic [OFF_IDX_W-1:0] HOME_OFFSET = '0;

    // Image shift codes, two's complement
    localparam logic [IMG_W-1:0] SHIFT_MINUS = 2'b11;
    localparam logic [IMG_W-1:0] SHIFT_NONE  = 2'b00;
    localparam logic [IMG_W-1:0] SHIFT_PLUS  = 2'b01;

    // Configuration register indices
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELLS_X    = 3'd0,
        CFG_CELLS_Y    = 3'd1,
        CFG_CELLS_Z    = 3'd2,
        CFG_PERIODIC_X = 3'd3,
        CFG_PERIODIC_Y = 3'd4,
        CFG_PERIODIC_Z = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [IMG_W-1:0] dx;
        logic [IMG_W-1:0] dy;
        logic [IMG_W-1:0] dz;
    } t_offset;

    // Offsets in emission order: the home cell first
    localparam t_offset HALF_SHELL [NUM_OFFSETS] = '{
        '{SHIFT_NONE,  SHIFT_NONE,  SHIFT_NONE},
        '{SHIFT_NONE,  SHIFT_NONE,  SHIFT_PLUS},
        '{SHIFT_NONE,  SHIFT_PLUS,  SHIFT_MINUS},
        '{SHIFT_NONE,  SHIFT_PLUS,  SHIFT_NONE},
        '{SHIFT_NONE,  SHIFT_PLUS,  SHIFT_PLUS},
        '{SHIFT_PLUS,  SHIFT_MINUS, SHIFT_MINUS},
        '{SHIFT_PLUS,  SHIFT_MINUS, SHIFT_NONE},
        '{SHIFT_PLUS,  SHIFT_MINUS, SHIFT_PLUS},
        '{SHIFT_PLUS,  SHIFT_NONE,  SHIFT_MINUS},
        '{SHIFT_PLUS,  SHIFT_NONE,  SHIFT_NONE},
        '{SHIFT_PLUS,  SHIFT_NONE,  SHIFT_PLUS},
        '{SHIFT_PLUS,  SHIFT_PLUS,  SHIFT_MINUS},
        '{SHIFT_PLUS,  SHIFT_PLUS,  SHIFT_NONE},
        '{SHIFT_PLUS,  SHIFT_PLUS,  SHIFT_PLUS}
    };

    // Effective grid settings seen by the generator
    typedef struct packed {
        logic [DIM_W-1:0]   nx;
        logic [DIM_W-1:0]   ny;
        logic [DIM_W-1:0]   nz;
        logic [PLANE_W-1:0] nynz;
        logic               per_x;
        logic               per_y;
        logic               per_z;
    } t_cfg;

    // One axis after the offset step
    typedef struct packed {
        logic [COORD_W-1:0] coord;
        logic [IMG_W-1:0]   shift;
    } t_axis;

    // One result pair
    typedef struct packed {
        logic [IDX_W-1:0] home;
        logic [IDX_W-1:0] nbr;
        logic [IMG_W-1:0] img_x;
        logic [IMG_W-1:0] img_y;
        logic [IMG_W-1:0] img_z;
        logic             last;
    } t_pair;

    // Generator status for the top level
    typedef struct packed {
        logic busy;
        logic emit;
        logic emit_last;
    } t_gen_status;

    // A zero dimension counts as one, an oversized one as the maximum.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DATA_W-1:0] raw);
        logic [DIM_W-1:0] res;
        res = DIM_W'(raw);
        if (raw == '0) begin
            res = DIM_W'(1);
        end else if (int'(raw) > MAX_CELLS_PER_AXIS) begin
            res = DIM_W'(MAX_CELLS_PER_AXIS);
        end
        return res;
    endfunction

    // A coordinate at or beyond the dimension is pulled back to the last cell.
    function automatic logic [COORD_W-1:0] clamp_coord(input logic [IN_COORD_W-1:0] c,
                                                       input logic [DIM_W-1:0] n);
        logic [DIM_W-1:0]   n_m1;
        logic [COORD_W-1:0] res;
        n_m1 = n - DIM_W'(1);
        res  = COORD_W'(c);
        if (int'(c) >= int'(n)) begin
            res = n_m1[COORD_W-1:0];
        end
        return res;
    endfunction

    // Steps one axis by the offset code with periodic wrap.
    function automatic t_axis axis_step(input logic [COORD_W-1:0] h,
                                        input logic [DIM_W-1:0] n,
                                        input logic [IMG_W-1:0] code);
        t_axis            res;
        logic [DIM_W-1:0] h_ext;
        logic [DIM_W-1:0] n_m1;
        h_ext     = {1'b0, h};
        n_m1      = n - DIM_W'(1);
        res.coord = h;
        res.shift = SHIFT_NONE;
        case (code)
            SHIFT_MINUS: begin
                if (h == '0) begin
                    res.coord = n_m1[COORD_W-1:0];
                    res.shift = SHIFT_MINUS;
                end else begin
                    res.coord = h - COORD_W'(1);
                end
            end
            SHIFT_PLUS: begin
                if (h_ext == n_m1) begin
                    res.coord = '0;
                    res.shift = SHIFT_PLUS;
                end else begin
                    res.coord = h + COORD_W'(1);
                end
            end
            default: begin
                res.coord = h;
                res.shift = SHIFT_NONE;
            end
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/half_shell_cell_pair_generator_top.sv */
// The first pair of a cell passes the home cell registers and then the output register on its way out.
// Throughput: one pair per cycle while the pair stream does not stall; a cell has 1 to 14 pairs,
// and the neighbour-index multipliers serve one offset per cycle.
// The next cell is taken in the cycle in which the last pair of the current one is sent.
// Reset (synchronous, active low) empties the pipeline and sets all dimensions to one
// cell and all axes to periodic.
`timescale 1ns / 1ps
`default_nettype none

module half_shell_cell_pair_generator_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Configuration write port
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [hscp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [hscp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Home cell stream
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // tdata: cell_x [5:0], cell_y [11:6], cell_z [17:12], zero [23:18]
    input  wire logic [hscp_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // Pair stream
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // tdata: home_index [17:0], neighbor_index [35:18], image_x [37:36],
    //        image_y [39:38], image_z [41:40], zero [47:42]
    output logic [hscp_pkg::M_TDATA_W-1:0]      o_m_tdata,
    output logic                                o_m_tlast
);
    import hscp_pkg::*;

    t_cfg        cfg;
    t_pair       pair;
    t_gen_status gen_status;
    logic        pair_valid;
    logic        out_adv;

    hscp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    hscp_gen u_gen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_s_tvalid),
        .i_in_x       (i_s_tdata[IN_COORD_W-1:0]),
        .i_in_y       (i_s_tdata[2*IN_COORD_W-1:IN_COORD_W]),
        .i_in_z       (i_s_tdata[3*IN_COORD_W-1:2*IN_COORD_W]),
        .o_in_ready   (o_s_tready),
        .i_out_ready  (out_adv),
        .o_pair_valid (pair_valid),
        .o_pair       (pair),
        .o_status     (gen_status)
    );

    hscp_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pair_valid (pair_valid),
        .i_pair       (pair),
        .o_adv        (out_adv),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tlast    (o_m_tlast)
    );

    // A new cell is only taken when the generator is free or finishing.
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (!gen_status.busy || gen_status.emit_last))
        else $error("input ready while a cell still has pairs to send");

    // A pair that is not the last keeps the generator busy.
    a_busy_after_mid_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (gen_status.emit && !gen_status.emit_last) |=> gen_status.busy)
        else $error("generator went idle before the last pair");

    // Reset leaves no pair pending anywhere.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && !gen_status.busy))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

/* rtl/hscp_cfg.sv */
// Configuration registers and the derived effective grid settings.
`timescale 1ns / 1ps
`default_nettype none

module hscp_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [hscp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [hscp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output hscp_pkg::t_cfg                      o_cfg
);
    import hscp_pkg::*;

    logic [CFG_DATA_W-1:0] r_cells_x, r_cells_y, r_cells_z;
    logic                  r_per_x, r_per_y, r_per_z;
    logic [PLANE_W-1:0]    r_nynz;
    logic [PLANE_W-1:0]    n_nynz;
    logic [DIM_W-1:0]      nx_eff, ny_eff, nz_eff;
    logic [2*DIM_W-1:0]    plane_prod;

    // Register writes; indices beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_x <= CFG_DATA_W'(1);
            r_cells_y <= CFG_DATA_W'(1);
            r_cells_z <= CFG_DATA_W'(1);
            r_per_x   <= 1'b1;
            r_per_y   <= 1'b1;
            r_per_z   <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_CELLS_X:    r_cells_x <= i_cfg_data;
                CFG_CELLS_Y:    r_cells_y <= i_cfg_data;
                CFG_CELLS_Z:    r_cells_z <= i_cfg_data;
                CFG_PERIODIC_X: r_per_x   <= i_cfg_data[0];
                CFG_PERIODIC_Y: r_per_y   <= i_cfg_data[0];
                CFG_PERIODIC_Z: r_per_z   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Effective dimensions and the size of one x plane.
    always_comb begin
        nx_eff     = eff_dim(r_cells_x);
        ny_eff     = eff_dim(r_cells_y);
        nz_eff     = eff_dim(r_cells_z);
        plane_prod = (2*DIM_W)'(ny_eff) * (2*DIM_W)'(nz_eff);
        n_nynz     = PLANE_W'(plane_prod);
    end

    // The plane size is registered so that the pair multiplier starts from a flop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nynz <= PLANE_W'(1);
        end else begin
            r_nynz <= n_nynz;
        end
    end

    assign o_cfg = '{nx: nx_eff, ny: ny_eff, nz: nz_eff, nynz: r_nynz,
                     per_x: r_per_x, per_y: r_per_y, per_z: r_per_z};

endmodule

`default_nettype wire

/* rtl/hscp_gen.sv */
// Home cell register and the walk over the half-shell offsets, one pair per cycle while the output can advance.
`timescale 1ns / 1ps
`default_nettype none

module hscp_gen (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire hscp_pkg::t_cfg                 i_cfg,
    input  wire logic                           i_in_valid,
    input  wire logic [hscp_pkg::IN_COORD_W-1:0] i_in_x,
    input  wire logic [hscp_pkg::IN_COORD_W-1:0] i_in_y,
    input  wire logic [hscp_pkg::IN_COORD_W-1:0] i_in_z,
    output logic                                o_in_ready,
    input  wire logic                           i_out_ready,
    output logic                                o_pair_valid,
    output hscp_pkg::t_pair                     o_pair,
    output hscp_pkg::t_gen_status               o_status
);
    import hscp_pkg::*;

    logic                   r_busy;
    logic [COORD_W-1:0]     r_hx, r_hy, r_hz;
    logic [NUM_OFFSETS-1:0] r_done;
    logic [IDX_W-1:0]       r_home;

    logic [NUM_OFFSETS-1:0] keep_mask;
    logic [NUM_OFFSETS-1:0] pending;
    logic [NUM_OFFSETS-1:0] pick_oh;
    logic [OFF_IDX_W-1:0]   sel;
    logic                   is_last;
    logic                   emit;
    logic                   take;
    t_axis                  mx, my, mz;
    t_axis                  ax, ay, az;
    logic [PROD_X_W-1:0]    prod_x;
    logic [PROD_Y_W-1:0]    prod_y;
    logic [IDX_W-1:0]       nbr_idx;

    // Offsets that survive the open-boundary check for the held home cell.
    always_comb begin
        for (int k = 0; k < NUM_OFFSETS; k++) begin
            mx = axis_step(r_hx, i_cfg.nx, HALF_SHELL[k].dx);
            my = axis_step(r_hy, i_cfg.ny, HALF_SHELL[k].dy);
            mz = axis_step(r_hz, i_cfg.nz, HALF_SHELL[k].dz);
            keep_mask[k] = !((mx.shift != SHIFT_NONE && !i_cfg.per_x) ||
                             (my.shift != SHIFT_NONE && !i_cfg.per_y) ||
                             (mz.shift != SHIFT_NONE && !i_cfg.per_z));
        end
    end

    // Lowest offset still to be sent, and whether it is the final one.
    always_comb begin
        pending = keep_mask & ~r_done;
        sel     = '0;
        for (int k = NUM_OFFSETS - 1; k >= 0; k--) begin
            if (pending[k]) begin
                sel = OFF_IDX_W'(k);
            end
        end
        pick_oh = NUM_OFFSETS'(1) << sel;
        is_last = (pending & ~pick_oh) == '0;
    end

    // Wrapped neighbour coordinates and its linear index.
    always_comb begin
        ax      = axis_step(r_hx, i_cfg.nx, HALF_SHELL[sel].dx);
        ay      = axis_step(r_hy, i_cfg.ny, HALF_SHELL[sel].dy);
        az      = axis_step(r_hz, i_cfg.nz, HALF_SHELL[sel].dz);
        prod_x  = PROD_X_W'(ax.coord) * PROD_X_W'(i_cfg.nynz);
        prod_y  = PROD_Y_W'(ay.coord) * PROD_Y_W'(i_cfg.nz);
        nbr_idx = IDX_W'(prod_x) + IDX_W'(prod_y) + IDX_W'(az.coord);
    end

    // Handshake: a new cell is taken as the last pair of the current one leaves.
    assign emit       = r_busy & i_out_ready;
    assign o_in_ready = ~r_busy | (emit & is_last);
    assign take       = i_in_valid & o_in_ready;

    // The home cell is always the first pair, so its index is the neighbour index there.
    always_comb begin
        o_pair_valid = emit;
        o_pair.home  = (sel == HOME_OFFSET) ? nbr_idx : r_home;
        o_pair.nbr   = nbr_idx;
        o_pair.img_x = ax.shift;
        o_pair.img_y = ay.shift;
        o_pair.img_z = az.shift;
        o_pair.last  = is_last;
    end

    assign o_status = '{busy: r_busy, emit: emit, emit_last: emit & is_last};

    // Busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (take) begin
            r_busy <= 1'b1;
        end else if (emit && is_last) begin
            r_busy <= 1'b0;
        end
    end

    // Home cell capture, sent-offset bookkeeping and home index.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_hx   <= clamp_coord(i_in_x, i_cfg.nx);
            r_hy   <= clamp_coord(i_in_y, i_cfg.ny);
            r_hz   <= clamp_coord(i_in_z, i_cfg.nz);
            r_done <= '0;
        end else if (emit) begin
            r_done <= r_done | pick_oh;
        end
        if (emit && sel == HOME_OFFSET) begin
            r_home <= nbr_idx;
        end
    end

endmodule

`default_nettype wire

/* rtl/hscp_out.sv */
// Output register for result pairs on the master stream side.
`timescale 1ns / 1ps
`default_nettype none

module hscp_out (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_pair_valid,
    input  wire hscp_pkg::t_pair               i_pair,
    output logic                               o_adv,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [hscp_pkg::M_TDATA_W-1:0]     o_m_tdata,
    output logic                               o_m_tlast
);
    import hscp_pkg::*;

    logic  r_valid;
    t_pair r_pair;

    // The register loads when empty or when its pair is being taken.
    assign o_adv = ~r_valid | i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_pair_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_pair <= i_pair;
        end
    end

    // Pack the fields, home index in the lowest bits.
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {M_PAD_W'(0), r_pair.img_z, r_pair.img_y, r_pair.img_x,
                         r_pair.nbr, r_pair.home};
    assign o_m_tlast  = r_pair.last;

endmodule

`default_nettype wire

/* test/hscp_pair_checker.sv */
// Watches the cell and pair streams of the pair generator, predicts every pair and compares.
`timescale 1ns / 1ps

module hscp_pair_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [hscp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [hscp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_s_tvalid,
    input  wire logic                            i_s_tready,
    // tdata: cell_x [5:0], cell_y [11:6], cell_z [17:12], zero [23:18]
    input  wire logic [hscp_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  wire logic                            i_m_tvalid,
    input  wire logic                            i_m_tready,
    // tdata: home_index [17:0], neighbor_index [35:18], image_x [37:36],
    //        image_y [39:38], image_z [41:40], zero [47:42]
    input  wire logic [hscp_pkg::M_TDATA_W-1:0]  i_m_tdata,
    input  wire logic                            i_m_tlast,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    import hscp_pkg::*;

    typedef struct {
        logic [IDX_W-1:0] home;
        logic [IDX_W-1:0] nbr;
        logic [IMG_W-1:0] img_x;
        logic [IMG_W-1:0] img_y;
        logic [IMG_W-1:0] img_z;
        logic             last;
    } t_cell_pair;

    // Half-shell offsets in the order in which the pairs leave the block.
    localparam int SHELL_DX [14] = '{0, 0, 0, 0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1};
    localparam int SHELL_DY [14] = '{0, 0, 1, 1, 1, -1, -1, -1, 0, 0, 0, 1, 1, 1};
    localparam int SHELL_DZ [14] = '{0, 1, -1, 0, 1, -1, 0, 1, -1, 0, 1, -1, 0, 1};

    logic [CFG_DATA_W-1:0] grid_raw [3];
    logic                  grid_periodic [3];
    t_cell_pair            expected_pairs [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // A zero size counts as one cell, an oversized one as the maximum.
    function automatic int axis_cells(input logic [CFG_DATA_W-1:0] raw);
        if (raw == '0) return 1;
        if (int'(raw) > MAX_CELLS_PER_AXIS) return MAX_CELLS_PER_AXIS;
        return int'(raw);
    endfunction

    // Moves one axis by the offset, wrapping at either end with an image shift.
    task automatic move_axis(input int c, input int off, input int n,
                             output int coord, output int shift);
        coord = c + off;
        shift = 0;
        if (coord < 0) begin
            coord = n - 1;
            shift = -1;
        end else if (coord > n - 1) begin
            coord = 0;
            shift = 1;
        end
    endtask

    // Works out the pairs of one home cell and queues them.
    task automatic queue_cell_pairs(input logic [S_TDATA_W-1:0] home_cell);
        int         n [3];
        int         h [3];
        int         r [3];
        int         s [3];
        int         offs [3];
        bit         dropped;
        t_cell_pair pairs [$];
        t_cell_pair p;
        for (int a = 0; a < 3; a++) begin
            n[a] = axis_cells(grid_raw[a]);
            h[a] = int'(home_cell[6*a +: 6]);
            if (h[a] >= n[a]) h[a] = n[a] - 1;
        end
        for (int k = 0; k < 14; k++) begin
            offs[0] = SHELL_DX[k];
            offs[1] = SHELL_DY[k];
            offs[2] = SHELL_DZ[k];
            dropped = 1'b0;
            for (int a = 0; a < 3; a++) begin
                move_axis(h[a], offs[a], n[a], r[a], s[a]);
                if (s[a] != 0 && !grid_periodic[a]) dropped = 1'b1;
            end
            if (!dropped) begin
                p.home  = IDX_W'(h[0] * n[1] * n[2] + h[1] * n[2] + h[2]);
                p.nbr   = IDX_W'(r[0] * n[1] * n[2] + r[1] * n[2] + r[2]);
                p.img_x = IMG_W'(s[0]);
                p.img_y = IMG_W'(s[1]);
                p.img_z = IMG_W'(s[2]);
                p.last  = 1'b0;
                pairs.push_back(p);
            end
        end
        pairs[pairs.size() - 1].last = 1'b1;
        foreach (pairs[i]) expected_pairs.push_back(pairs[i]);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: pair mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    // Compares one pair transfer with the oldest expectation.
    task automatic check_pair(input logic [M_TDATA_W-1:0] data, input logic last);
        t_cell_pair want;
        if (expected_pairs.size() == 0) begin
            $display("%0t: pair transfer with nothing expected: %0h", $realtime, data);
            o_fail_count++;
            return;
        end
        want = expected_pairs.pop_front();
        if (data[17:0] !== want.home)   report_mismatch("home_index", data[17:0], want.home);
        if (data[35:18] !== want.nbr)   report_mismatch("neighbor_index", data[35:18], want.nbr);
        if (data[37:36] !== want.img_x) report_mismatch("image_x", data[37:36], want.img_x);
        if (data[39:38] !== want.img_y) report_mismatch("image_y", data[39:38], want.img_y);
        if (data[41:40] !== want.img_z) report_mismatch("image_z", data[41:40], want.img_z);
        if (last !== want.last)         report_mismatch("last_pair", last, want.last);
    endtask

    // All channels are sampled at the clock edge; pairs are checked before new cells queue.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                grid_raw[a]      = CFG_DATA_W'(1);
                grid_periodic[a] = 1'b1;
            end
            expected_pairs.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_CELLS_X:    grid_raw[0] = i_cfg_data;
                    CFG_CELLS_Y:    grid_raw[1] = i_cfg_data;
                    CFG_CELLS_Z:    grid_raw[2] = i_cfg_data;
                    CFG_PERIODIC_X: grid_periodic[0] = i_cfg_data[0];
                    CFG_PERIODIC_Y: grid_periodic[1] = i_cfg_data[0];
                    CFG_PERIODIC_Z: grid_periodic[2] = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) check_pair(i_m_tdata, i_m_tlast);
            if (i_s_tvalid && i_s_tready) queue_cell_pairs(i_s_tdata);
        end
        o_pending = expected_pairs.size();
    end

endmodule

/* test/half_shell_cell_pair_generator_top_tb.sv */
// Stimulus and verdict for the half-shell cell pair generator; checking lives in the checker.
`timescale 1ns / 1ps

module half_shell_cell_pair_generator_top_tb;
    import hscp_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  i_s_tvalid   = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata    = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready   = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  o_m_tlast;

    int fail_count;
    int pairs_pending;
    int cycle_count = 0;
    int burst_left  = 0;
    bit tx_calm     = 1'b0;
    bit rx_calm     = 1'b0;
    bit rx_stalled  = 1'b0;
    int rx_left     = 0;
    int grid_cells [3];

    half_shell_cell_pair_generator_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    hscp_pair_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pairs_pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The pair receiver alternates ready runs and stalls of random length, unless rx_calm holds ready high.
    always @(posedge i_clk) begin
        if (rx_left > 0) begin
            rx_left--;
        end else begin
            rx_stalled = !rx_stalled;
            rx_left    = rx_stalled ? $urandom_range(0, 5) : $urandom_range(0, 12);
        end
        i_m_tready <= rx_calm || !rx_stalled;
    end

    // Writes all six grid registers on consecutive cycles; the block must be idle.
    task automatic set_grid(input logic [6:0] nx, input logic [6:0] ny, input logic [6:0] nz,
                            input bit px, input bit py, input bit pz);
        t_cfg_reg        regs [6];
        logic [6:0]      vals [6];
        logic [6:0]      raws [3];
        regs = '{CFG_CELLS_X, CFG_CELLS_Y, CFG_CELLS_Z,
                 CFG_PERIODIC_X, CFG_PERIODIC_Y, CFG_PERIODIC_Z};
        // Upper bits of the flag writes carry noise that the block must ignore.
        vals = '{nx, ny, nz, {6'($urandom), px}, {6'($urandom), py}, {6'($urandom), pz}};
        raws = '{nx, ny, nz};
        for (int i = 0; i < 6; i++) begin
            @(posedge i_clk);
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= regs[i];
            i_cfg_data  <= vals[i];
        end
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        for (int a = 0; a < 3; a++) begin
            grid_cells[a] = raws[a] == 0 ? 1 : (raws[a] > 64 ? 64 : int'(raws[a]));
        end
    endtask

    // Offers one home cell and returns at the edge of its transfer.
    task automatic send_cell(input logic [5:0] x, input logic [5:0] y, input logic [5:0] z);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = tx_calm ? 0 : $urandom_range(0, 20);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'b0, z, y, x};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Lowers the cell stream and waits for every queued pair, plus a short margin.
    task automatic drain;
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pairs_pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Coordinates mostly sit on the faces of the grid, some anywhere, some beyond it.
    function automatic logic [5:0] pick_coord(input int n);
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 6'd0;
        if (r < 6) return 6'(n - 1);
        if (r < 9) return 6'($urandom_range(0, n - 1));
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic logic [6:0] pick_size;
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 7'd0;
        if (r == 1) return 7'd64;
        if (r == 2) return 7'($urandom_range(65, 127));
        if (r < 6) return 7'($urandom_range(1, 64));
        return 7'($urandom_range(1, 6));
    endfunction

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset grid of one cell per axis, all periodic: every neighbour is the home cell.
        send_cell(6'd0, 6'd0, 6'd0);
        send_cell(6'd63, 6'd63, 6'd63);
        drain();

        // Largest periodic grid: corners and alternating bit patterns.
        set_grid(7'd64, 7'd64, 7'd64, 1'b1, 1'b1, 1'b1);
        send_cell(6'd0, 6'd0, 6'd0);
        send_cell(6'd63, 6'd63, 6'd63);
        send_cell(6'd63, 6'd0, 6'd63);
        send_cell(6'd32, 6'd31, 6'd1);
        send_cell(6'd42, 6'd21, 6'd42);
        send_cell(6'd21, 6'd42, 6'd21);
        drain();

        // Zero and oversized sizes on open axes.
        set_grid(7'd0, 7'd127, 7'd65, 1'b0, 1'b0, 1'b0);
        send_cell(6'd0, 6'd63, 6'd63);
        send_cell(6'd5, 6'd0, 6'd0);
        send_cell(6'd0, 6'd63, 6'd0);
        drain();

        // Small mixed grid with coordinates beyond the edge.
        set_grid(7'd3, 7'd4, 7'd5, 1'b0, 1'b1, 1'b0);
        send_cell(6'd0, 6'd0, 6'd0);
        send_cell(6'd2, 6'd3, 6'd4);
        send_cell(6'd1, 6'd2, 6'd3);
        send_cell(6'd2, 6'd0, 6'd4);
        send_cell(6'd10, 6'd10, 6'd10);
        drain();

        // Fully open grid: the far corner has only its own pair.
        set_grid(7'd64, 7'd64, 7'd64, 1'b0, 1'b0, 1'b0);
        send_cell(6'd63, 6'd63, 6'd63);
        send_cell(6'd0, 6'd0, 6'd0);
        send_cell(6'd63, 6'd0, 6'd0);
        drain();

        // Random grids, each with its own pace on both streams.
        for (int phase = 0; phase < 10; phase++) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            set_grid(pick_size(), pick_size(), pick_size(),
                     1'($urandom), 1'($urandom), 1'($urandom));
            for (int i = 0; i < 25; i++) begin
                send_cell(pick_coord(grid_cells[0]), pick_coord(grid_cells[1]),
                          pick_coord(grid_cells[2]));
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
